// ===== rtl/chs_pkg.sv =====
// chs_pkg: shared sizes, operation codes, row result struct and bucket hash
// no dependencies; imported by chs_row_logic and chained_hash_set
package chs_pkg;

  localparam int BUCKETS      = 7;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_W        = 32;
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int ROW_W        = KEY_W * BUCKET_DEPTH;

  typedef logic [1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  typedef logic [BUCKET_DEPTH-1:0]            row_valid_t;
  typedef logic [BUCKET_DEPTH-1:0][KEY_W-1:0] row_keys_t;

  typedef struct packed {
    logic found;
    logic bucket_full;
    logic key_we;
    logic valid_we;
  } row_res_t;

  // key mod 7: 8 == 1 (mod 7), so octal digits sum to the same residue
  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [35:0] kx;
    logic [5:0]  lo;
    logic [5:0]  hi;
    logic [6:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    kx = {4'b0, key};
    lo = '0;
    hi = '0;
    for (int i = 0; i < 6; i++) begin
      lo = lo + 6'(kx[3*i +: 3]);
      hi = hi + 6'(kx[3*(i+6) +: 3]);
    end
    s1 = 7'(lo) + 7'(hi);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'(BUCKETS)) begin
      return BKT_W'(s3 - 4'(BUCKETS));
    end
    return s3[BKT_W-1:0];
  endfunction

endpackage

// ===== rtl/chs_ram.sv =====
// chs_ram: generic single-port synchronous ram, registered read
// no dependencies; holds the key rows of the hash set
module chs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/chs_row_logic.sv =====
// chs_row_logic: compares all slots of one bucket row and builds the updated row
// depends on chs_pkg
module chs_row_logic import chs_pkg::*; (
  input  op_t              op,
  input  logic [KEY_W-1:0] key,
  input  row_keys_t        row_keys,
  input  row_valid_t       row_valid,
  output row_keys_t        new_keys,
  output row_valid_t       new_valid,
  output row_res_t         res
);

  row_valid_t match;
  row_valid_t match_oh;
  row_valid_t free_oh;
  logic       any_match;
  logic       row_full;

  always_comb begin
    for (int s = 0; s < BUCKET_DEPTH; s++) begin
      match[s] = row_valid[s] && (row_keys[s] == key);
    end
  end

  // lowest set bit of match, lowest clear bit of valid
  assign match_oh  = match & (~match + BUCKET_DEPTH'(1));
  assign free_oh   = ~row_valid & (row_valid + BUCKET_DEPTH'(1));
  assign any_match = |match;
  assign row_full  = &row_valid;

  always_comb begin
    for (int s = 0; s < BUCKET_DEPTH; s++) begin
      new_keys[s] = free_oh[s] ? key : row_keys[s];
    end
  end

  always_comb begin
    new_valid = row_valid;
    res       = '0;
    case (op)
      OP_INSERT: begin
        res.bucket_full = row_full;
        res.key_we      = !row_full;
        res.valid_we    = !row_full;
        new_valid       = row_valid | free_oh;
      end
      OP_SEARCH: begin
        res.found = any_match;
      end
      OP_REMOVE: begin
        res.found    = any_match;
        res.valid_we = any_match;
        new_valid    = row_valid & ~match_oh;
      end
      default: begin
        new_valid = row_valid;
      end
    endcase
  end

endmodule

// ===== rtl/chained_hash_set.sv =====
// chained_hash_set: hash set, 7 buckets of fixed depth, separate chaining
// depends on chs_pkg, chs_ram, chs_row_logic
//
//  channel   ports                              handshake
//  request   in_operation, in_key               start && !busy
//  result    out_found, out_bucket_full         out_strobe, one cycle, no backpressure
//
// - at accept the bucket row is read from the key ram; in the look state all
//   slots are compared, the row is written back and the result is registered,
//   which shows on the following cycle
// - the rate is set by the registered read of the single-port key ram
//   and the read-modify-write of one row per request
// - busy is high for the single cycle between accept and write-back
// - reset clears the slot valid flops at once; no clearing pass, keys are
//   only compared where the valid bit is set
// - the receiver cannot stall; each result word is shown for one cycle only
module chained_hash_set import chs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  op_t              in_operation,
  input  logic [KEY_W-1:0] in_key,
  output logic             out_strobe,
  output logic             out_found,
  output logic             out_bucket_full
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [BKT_W-1:0] bucket_r;
  row_valid_t       valid_r [BUCKETS];

  logic             out_strobe_r;
  logic             out_found_r;
  logic             out_bucket_full_r;

  logic             accept;
  logic             look;
  logic [BKT_W-1:0] in_bucket;
  logic [BKT_W-1:0] ram_addr;
  logic [ROW_W-1:0] ram_rdata;
  row_keys_t        row_keys;
  row_valid_t       row_valid;
  row_keys_t        new_keys;
  row_valid_t       new_valid;
  row_res_t         res;

  assign look      = (state_r == S_LOOK);
  assign busy      = look;
  assign accept    = start && !busy;
  assign in_bucket = bucket_of(in_key);

  // read the row at accept, write it back in the look cycle
  assign ram_addr  = look ? bucket_r : in_bucket;
  assign row_keys  = row_keys_t'(ram_rdata);
  assign row_valid = valid_r[bucket_r];

  chs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_key_ram (
    .clk   (clk),
    .we    (look && res.key_we),
    .addr  (ram_addr),
    .wdata (ROW_W'(new_keys)),
    .rdata (ram_rdata)
  );

  chs_row_logic u_row (
    .op        (op_r),
    .key       (key_r),
    .row_keys  (row_keys),
    .row_valid (row_valid),
    .new_keys  (new_keys),
    .new_valid (new_valid),
    .res       (res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and slot valid flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= look;
      if (look && res.valid_we) begin
        valid_r[bucket_r] <= new_valid;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      key_r    <= in_key;
      bucket_r <= in_bucket;
    end
    if (look) begin
      out_found_r       <= res.found;
      out_bucket_full_r <= res.bucket_full;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_found       = out_found_r;
  assign out_bucket_full = out_bucket_full_r;

  // a result word only follows a look cycle
  a_strobe_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(look))
    else $error("result strobe without a preceding look cycle");

  // insert rejection and a hit never come together
  a_found_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_found && out_bucket_full))
    else $error("found and bucket_full both set");

  // a successful remove clears exactly one slot of its bucket
  a_remove_one: assert property (@(posedge clk) disable iff (!rst_n)
    (look && op_r == OP_REMOVE && res.found) |=>
      ($countones(valid_r[bucket_r]) + 1 == $countones($past(row_valid))))
    else $error("remove did not clear exactly one slot");

  // a successful insert sets exactly one slot of its bucket
  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    (look && op_r == OP_INSERT && !res.bucket_full) |=>
      ($countones(valid_r[bucket_r]) == $countones($past(row_valid)) + 1))
    else $error("insert did not set exactly one slot");

endmodule
